FILE: rtl/moving_average_filter_top_defines.svh
// Assertion macros used by the moving average filter top level
`ifndef MOVING_AVERAGE_FILTER_TOP_DEFINES_SVH
`define MOVING_AVERAGE_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define MAF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define MAF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mavg_pkg.sv
// Shared constants, codes and control structs of the moving average filter
`timescale 1ns / 1ps

package mavg_pkg;

    // Default sizes
    localparam int DEPTH_DEF        = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Configuration register layout
    localparam int WL_W       = 7;
    localparam int SA_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_AMOUNT  = 2'd1;

    localparam logic [WL_W-1:0] WL_RESET = 7'd16;
    localparam logic [SA_W-1:0] SA_RESET = 3'd0;

    // How the back end turns the sum into an average
    typedef enum logic {
        OP_DIV,
        OP_SHIFT
    } t_op;

    // Queue head as seen by the back end
    typedef struct packed {
        logic avail;
        t_op  op;
    } t_job_ctl;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Back end status
    typedef struct packed {
        logic busy;
        logic filled;
    } t_back_stat;

endpackage

FILE: rtl/moving_average_filter_top.sv
// Each input beat goes through the queue, then the sequencer states read, calc and out to the
// output register; dividing by the window length adds a pass through the bit-serial divider.
// The back end finishes one sample before it takes the next one from the queue.
// A two-beat input queue and the output register let both sides stall on their own.
// Reset (synchronous, active low) clears the queue, sum, position, fill flag and the
// sample valid bits; window_length returns to 16 and shift_amount to 0.
`timescale 1ns / 1ps

`include "moving_average_filter_top_defines.svh"

module moving_average_filter_top
    import mavg_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [CFG_DATA_W-1:0]          i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_average,
    output logic                           o_average_valid
);

    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int SUM_W = SAMPLE_WIDTH + $clog2(DEPTH);

    logic [WL_W-1:0]         r_window_length;
    logic [SA_W-1:0]         r_shift_amount;
    logic [LEN_W-1:0]        eff_len;
    logic                    cfg_we;
    logic                    clear;

    t_job_ctl                job_ctl;
    logic signed [SAMPLE_WIDTH-1:0] job_sample;
    logic                    pop;
    logic                    div_start;
    logic signed [SUM_W-1:0] div_dividend;
    logic signed [SUM_W-1:0] div_quot;
    t_div_stat               div_stat;
    t_back_stat              back_stat;

    // Register writes are always taken
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign clear       = cfg_we && (i_cfg_index == REG_WINDOW_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WL_RESET;
            r_shift_amount  <= SA_RESET;
        end else if (cfg_we) begin
            if (i_cfg_index == REG_WINDOW_LENGTH) begin
                r_window_length <= i_cfg_data[WL_W-1:0];
            end else if (i_cfg_index == REG_SHIFT_AMOUNT) begin
                r_shift_amount <= i_cfg_data[SA_W-1:0];
            end
        end
    end

    // Effective window: zero reads as one, long windows clip to the ring depth
    always_comb begin
        if (r_window_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (32'(r_window_length) > 32'(DEPTH)) begin
            eff_len = LEN_W'(DEPTH);
        end else begin
            eff_len = LEN_W'(r_window_length);
        end
    end

    mavg_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .i_shift_amount (r_shift_amount),
        .i_pop          (pop),
        .o_job_ctl      (job_ctl),
        .o_job_sample   (job_sample)
    );

    mavg_div #(
        .DEPTH        (DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (eff_len),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    mavg_back #(
        .DEPTH        (DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_clear         (clear),
        .i_len           (eff_len),
        .i_shift_amount  (r_shift_amount),
        .i_job_ctl       (job_ctl),
        .i_job_sample    (job_sample),
        .o_pop           (pop),
        .o_div_start     (div_start),
        .o_div_dividend  (div_dividend),
        .i_div_stat      (div_stat),
        .i_div_quot      (div_quot),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_average       (o_average),
        .o_average_valid (o_average_valid),
        .o_stat          (back_stat)
    );

    // Checks
    `MAF_ASSERT_NOW(a_zero_before_fill, i_clk, i_rst_n, o_out_valid && !o_average_valid, o_average == '0, "average nonzero before window filled")
    `MAF_ASSERT_NEXT(a_clear_drops_fill, i_clk, i_rst_n, clear, !back_stat.filled, "window length write left window filled")
    `MAF_ASSERT_NOW(a_div_owned, i_clk, i_rst_n, div_stat.busy, back_stat.busy, "divider running while back end idle")

endmodule

FILE: rtl/mavg_front.sv
// Front end: accepts sample beats, tags the averaging mode, two-entry queue
`timescale 1ns / 1ps

module mavg_front
    import mavg_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic        [SA_W-1:0]         i_shift_amount,
    input  logic                           i_pop,
    output t_job_ctl                       o_job_ctl,
    output logic signed [SAMPLE_WIDTH-1:0] o_job_sample
);

    logic                           r_wr_ptr, n_wr_ptr;
    logic                           r_rd_ptr, n_rd_ptr;
    logic [1:0]                     r_count, n_count;
    logic signed [SAMPLE_WIDTH-1:0] r_q_sample [2];
    t_op                            r_q_op     [2];
    logic                           push;
    logic                           pop;
    t_op                            beat_op;

    // Full queue holds off the sender
    assign o_in_stall = (r_count == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_pop && (r_count != 2'd0);

    // Classify: shift amount zero means a true divide
    assign beat_op = (i_shift_amount == '0) ? OP_DIV : OP_SHIFT;

    // Queue head
    assign o_job_ctl.avail = (r_count != 2'd0);
    assign o_job_ctl.op    = r_q_op[r_rd_ptr];
    assign o_job_sample    = r_q_sample[r_rd_ptr];

    // Pointer and count update
    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_sample[r_wr_ptr] <= i_sample;
            r_q_op[r_wr_ptr]     <= beat_op;
        end
    end

endmodule

FILE: rtl/mavg_div.sv
// Restoring divider: signed sum by window length, one quotient bit a cycle
`timescale 1ns / 1ps

module mavg_div
    import mavg_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_start,
    input  logic signed [SAMPLE_WIDTH+$clog2(DEPTH)-1:0]    i_dividend,
    input  logic        [$clog2(DEPTH+1)-1:0]               i_divisor,
    output t_div_stat                                       o_stat,
    output logic signed [SAMPLE_WIDTH+$clog2(DEPTH)-1:0]    o_quot
);

    localparam int SUM_W = SAMPLE_WIDTH + $clog2(DEPTH);
    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [LEN_W:0]   r_rem;
    logic [SUM_W-1:0] r_q;
    logic [LEN_W-1:0] r_div;
    logic             r_neg;
    logic [LEN_W:0]   rem_sh;
    logic             ge;
    logic [SUM_W-1:0] mag;

    // Dividend magnitude; the most negative sum maps onto itself, still correct unsigned
    assign mag = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);

    // One trial subtraction per cycle
    assign rem_sh = {r_rem[LEN_W-1:0], r_q[SUM_W-1]};
    assign ge     = (rem_sh >= {1'b0, r_div});

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_neg ? -$signed(r_q) : $signed(r_q);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= mag;
            r_rem <= '0;
            r_div <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_busy) begin
            r_rem <= ge ? (rem_sh - {1'b0, r_div}) : rem_sh;
            r_q   <= {r_q[SUM_W-2:0], ge};
        end
    end

endmodule

FILE: rtl/mavg_back.sv
// Back end: sample ring, running sum, averaging sequencer and output register
`timescale 1ns / 1ps

module mavg_back
    import mavg_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_clear,
    input  logic        [$clog2(DEPTH+1)-1:0]            i_len,
    input  logic        [SA_W-1:0]                       i_shift_amount,
    input  t_job_ctl                                     i_job_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0]               i_job_sample,
    output logic                                         o_pop,
    output logic                                         o_div_start,
    output logic signed [SAMPLE_WIDTH+$clog2(DEPTH)-1:0] o_div_dividend,
    input  t_div_stat                                    i_div_stat,
    input  logic signed [SAMPLE_WIDTH+$clog2(DEPTH)-1:0] i_div_quot,
    output logic                                         o_out_valid,
    input  logic                                         i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]               o_average,
    output logic                                         o_average_valid,
    output t_back_stat                                   o_stat
);

    localparam int AW    = $clog2(DEPTH);
    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int SUM_W = SAMPLE_WIDTH + $clog2(DEPTH);

    localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_CALC = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]                     r_state, n_state;
    logic signed [SAMPLE_WIDTH-1:0] r_sample, n_sample;
    t_op                            r_op, n_op;
    logic signed [SUM_W-1:0]        r_sum, n_sum;
    logic [AW-1:0]                  r_pos, n_pos;
    logic                           r_filled, n_filled;
    logic [DEPTH-1:0]               r_valid, n_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_result, n_result;
    logic                           r_res_flag, n_res_flag;
    logic                           r_out_valid, n_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_avg, n_out_avg;
    logic                           r_out_flag, n_out_flag;

    logic signed [SAMPLE_WIDTH-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] r_rdata;
    logic                           mem_we;

    logic [AW-1:0]                  pos_eff;
    logic [LEN_W-1:0]               pos_inc;
    logic                           wrap;
    logic signed [SAMPLE_WIDTH-1:0] old_sample;
    logic                           out_free;

    // Clamp a wide value into the sample range
    function automatic logic signed [SAMPLE_WIDTH-1:0] sat(input logic signed [SUM_W-1:0] v);
        logic signed [SAMPLE_WIDTH-1:0] res;
        res = SAMPLE_WIDTH'(v);
        if (v > SUM_W'(SMAX)) begin
            res = SMAX;
        end else if (v < SUM_W'(SMIN)) begin
            res = SMIN;
        end
        return res;
    endfunction

    // Ring position, folded back if beyond the window
    assign pos_eff    = (LEN_W'(r_pos) >= i_len) ? '0 : r_pos;
    assign pos_inc    = LEN_W'(pos_eff) + LEN_W'(1);
    assign wrap       = (pos_inc >= i_len);
    assign old_sample = r_valid[pos_eff] ? r_rdata : '0;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign o_pop           = (r_state == S_IDLE) && i_job_ctl.avail;
    assign mem_we          = (r_state == S_READ);
    assign o_div_start     = (r_state == S_CALC) && r_filled && (r_op == OP_DIV);
    assign o_div_dividend  = r_sum;
    assign o_out_valid     = r_out_valid;
    assign o_average       = r_out_avg;
    assign o_average_valid = r_out_flag;
    assign o_stat.busy     = (r_state != S_IDLE);
    assign o_stat.filled   = r_filled;

    // Sequencer and sum update
    always_comb begin
        n_state     = r_state;
        n_sample    = r_sample;
        n_op        = r_op;
        n_sum       = r_sum;
        n_pos       = r_pos;
        n_filled    = r_filled;
        n_valid     = r_valid;
        n_result    = r_result;
        n_res_flag  = r_res_flag;
        n_out_valid = r_out_valid;
        n_out_avg   = r_out_avg;
        n_out_flag  = r_out_flag;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_job_ctl.avail) begin
                    n_sample = i_job_sample;
                    n_op     = i_job_ctl.op;
                    n_state  = S_READ;
                end
            end
            S_READ: begin
                // Drop the leaving sample, add the new one
                n_sum            = r_sum - SUM_W'(old_sample) + SUM_W'(r_sample);
                n_valid[pos_eff] = 1'b1;
                n_pos            = wrap ? '0 : AW'(pos_inc);
                n_filled         = r_filled | wrap;
                n_state          = S_CALC;
            end
            S_CALC: begin
                n_res_flag = r_filled;
                if (!r_filled) begin
                    n_result = '0;
                    n_state  = S_OUT;
                end else if (r_op == OP_SHIFT) begin
                    n_result = sat(r_sum >>> i_shift_amount);
                    n_state  = S_OUT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_div_stat.done) begin
                    n_result = sat(i_div_quot);
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_avg   = r_result;
                    n_out_flag  = r_res_flag;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Window length write wipes the window
        if (i_clear) begin
            n_sum    = '0;
            n_pos    = '0;
            n_filled = 1'b0;
            n_valid  = '0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_pos       <= '0;
            r_filled    <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_pos       <= n_pos;
            r_filled    <= n_filled;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_sample   <= n_sample;
        r_op       <= n_op;
        r_result   <= n_result;
        r_res_flag <= n_res_flag;
        r_out_avg  <= n_out_avg;
        r_out_flag <= n_out_flag;
    end

    // Sample ring, registered read at the current position
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[pos_eff] <= r_sample;
        end
        r_rdata <= r_mem[pos_eff];
    end

endmodule

FILE: tb/sv/moving_average_filter_top_test.sv
// Self-checking testbench for the moving average filter: directed cases, back-pressure, random
`timescale 1ns / 1ps

module moving_average_filter_top_test;
    import mavg_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;      // a little over the divide latency
    localparam int RANDOM_ITEMS  = 800;
    localparam int HOLD_OFF      = 300;
    localparam int REPORT_MAX    = 10;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam longint AVG_MAX = 32767;
    localparam longint AVG_MIN = -32768;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef enum int {
        BIAS_MIXED,
        BIAS_HIGH,
        BIAS_LOW
    } t_sample_bias;

    typedef struct packed {
        logic [SAMPLE_WIDTH_DEF-1:0] average;
        logic                        average_valid;
    } t_avg_result;

    // DUT connections
    logic                               i_clk;
    logic                               i_rst_n         = 1'b0;
    logic                               i_cfg_valid     = 1'b0;
    logic                               o_cfg_ready;
    logic [CFG_IDX_W-1:0]               i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0]              i_cfg_data      = '0;
    logic                               i_in_valid      = 1'b0;
    logic                               o_in_stall;
    logic signed [SAMPLE_WIDTH_DEF-1:0] i_sample        = '0;
    logic                               o_out_valid;
    logic                               i_out_stall     = 1'b0;
    logic signed [SAMPLE_WIDTH_DEF-1:0] o_average;
    logic                               o_average_valid;

    // Predicted filter state
    logic [WL_W-1:0] win_len    = WL_RESET;
    logic [SA_W-1:0] shift_amt  = SA_RESET;
    longint          ring_store [DEPTH_DEF];
    longint          win_sum    = 0;
    int unsigned     wr_pos     = 0;
    bit              win_filled = 1'b0;

    t_avg_result pending_averages[$];

    // Run control and statistics
    int send_idle_pct      = 0;
    int recv_stall_pct     = 0;
    int hold_off_left      = 0;
    int cycle_count        = 0;
    int samples_sent       = 0;
    int averages_checked   = 0;
    int mismatches         = 0;
    int cfg_writes         = 0;
    int input_stall_cycles = 0;

    moving_average_filter_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_average      (o_average),
        .o_average_valid(o_average_valid)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        foreach (ring_store[k]) ring_store[k] = 0;
    end

    // Predict the average after one accepted sample beat
    task automatic advance_window(input logic signed [SAMPLE_WIDTH_DEF-1:0] smp);
        int unsigned len;
        longint      avg;
        t_avg_result res;
        len = (win_len == '0) ? 1 :
              ((int'(win_len) > DEPTH_DEF) ? DEPTH_DEF : int'(win_len));
        if (wr_pos >= len) wr_pos = 0;
        win_sum = win_sum - ring_store[wr_pos] + longint'(smp);
        ring_store[wr_pos] = longint'(smp);
        wr_pos++;
        if (wr_pos >= len) begin
            wr_pos = 0;
            win_filled = 1'b1;
        end
        avg = 0;
        if (win_filled) begin
            if (shift_amt == '0) avg = win_sum / longint'(len);
            else avg = win_sum >>> shift_amt;
            if (avg > AVG_MAX) avg = AVG_MAX;
            if (avg < AVG_MIN) avg = AVG_MIN;
        end
        res.average       = avg[SAMPLE_WIDTH_DEF-1:0];
        res.average_valid = win_filled;
        pending_averages.push_back(res);
    endtask

    // Monitor: check result beats, track register writes, predict on sample beats
    always @(posedge i_clk) begin : monitor
        t_avg_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                averages_checked++;
                if (pending_averages.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result beat: average %0d valid %0b",
                                 o_average, o_average_valid);
                end else begin
                    want = pending_averages.pop_front();
                    if (want.average !== o_average ||
                        want.average_valid !== o_average_valid) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("result %0d: average exp %0d got %0d, valid exp %0b got %0b",
                                     averages_checked, $signed(want.average), o_average,
                                     want.average_valid, o_average_valid);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_WINDOW_LENGTH) begin
                    win_len = i_cfg_data[WL_W-1:0];
                    foreach (ring_store[k]) ring_store[k] = 0;
                    win_sum    = 0;
                    wr_pos     = 0;
                    win_filled = 1'b0;
                end else if (i_cfg_index == REG_SHIFT_AMOUNT) begin
                    shift_amt = i_cfg_data[SA_W-1:0];
                end
            end
            if (i_in_valid && o_in_stall) input_stall_cycles++;
            if (i_in_valid && !o_in_stall) advance_window(i_sample);
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            i_out_stall = 1'b1;
            hold_off_left--;
        end else begin
            i_out_stall = ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL moving_average_filter_top");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the beat
    task automatic send_sample(input logic signed [SAMPLE_WIDTH_DEF-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_sample   = value;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        samples_sent++;
    endtask

    // Wait for every predicted average, then let the back end settle
    task automatic drain_results();
        i_in_valid = 1'b0;
        while (pending_averages.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        drain_results();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        cfg_writes++;
    endtask

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_SENDER: begin
                send_idle_pct  = 58;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 58;
            end
            IDLE_BOTH: begin
                send_idle_pct  = 9;
                recv_stall_pct = 9;
            end
            default: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    function automatic logic signed [SAMPLE_WIDTH_DEF-1:0] pick_sample(input t_sample_bias bias);
        logic signed [SAMPLE_WIDTH_DEF-1:0] v;
        case (bias)
            BIAS_HIGH: v = 16'sh7FFF - 16'($urandom_range(0, 800));
            BIAS_LOW:  v = 16'sh8000 + 16'($urandom_range(0, 800));
            default: begin
                case ($urandom_range(0, 7))
                    0:       v = 16'sh7FFF;
                    1:       v = 16'sh8000;
                    2:       v = 16'sh0000;
                    3:       v = -16'sd1;
                    default: v = 16'($urandom);
                endcase
            end
        endcase
        return v;
    endfunction

    // Reset values: window of 16 with true division
    task automatic test_reset_defaults();
        repeat (16) send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        drain_results();
    endtask

    // Zero length acts as one; one gives the sample itself
    task automatic test_window_extremes();
        write_register(REG_WINDOW_LENGTH, 7'd0);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        write_register(REG_WINDOW_LENGTH, 7'd1);
        send_sample(-16'sd1);
        drain_results();
    endtask

    // Truncating division, flooring shift, high data bits of the shift ignored, saturation
    task automatic test_shift_modes();
        write_register(REG_WINDOW_LENGTH, 7'd2);
        write_register(REG_SHIFT_AMOUNT, 7'd0);
        send_sample(-16'sd1);
        send_sample(-16'sd2);
        write_register(REG_SHIFT_AMOUNT, 7'd1);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        write_register(REG_SHIFT_AMOUNT, 7'h7F);
        send_sample(16'sh7FFF);
        write_register(REG_WINDOW_LENGTH, 7'd4);
        write_register(REG_SHIFT_AMOUNT, 7'd1);
        repeat (3) send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        drain_results();
    endtask

    // Writes to spare indexes change nothing
    task automatic test_spare_indexes();
        write_register(REG_SPARE_2, 7'h7F);
        write_register(REG_SPARE_3, 7'h00);
        send_sample(16'sh1234);
        drain_results();
    endtask

    // Receiver holds off while the sender keeps going, so the input stalls
    task automatic test_backpressure();
        write_register(REG_WINDOW_LENGTH, 7'd8);
        write_register(REG_SHIFT_AMOUNT, 7'd3);
        set_idling(IDLE_NONE);
        @(posedge i_clk);
        hold_off_left = HOLD_OFF;
        @(negedge i_clk);
        repeat (20) send_sample(pick_sample(BIAS_MIXED));
        drain_results();
    endtask

    // Random phases: new settings, idling mode and sample bias per phase
    task automatic test_random();
        int                    phase;
        int                    sent;
        int                    count;
        int                    eff_len;
        logic [CFG_DATA_W-1:0] len_data;
        logic [CFG_DATA_W-1:0] shift_data;
        t_sample_bias          bias;
        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ITEMS) begin
            case (phase)
                0: len_data = 7'd127;
                1: len_data = 7'd64;
                default: begin
                    case ($urandom_range(0, 5))
                        0:       len_data = 7'd0;
                        1:       len_data = 7'd1;
                        2:       len_data = 7'd64;
                        3:       len_data = 7'($urandom_range(65, 127));
                        default: len_data = 7'($urandom_range(2, 20));
                    endcase
                end
            endcase
            case ($urandom_range(0, 3))
                1:       shift_data = 7'($urandom_range(1, 7));
                2:       shift_data = 7'($urandom);
                default: shift_data = 7'd0;
            endcase
            write_register(REG_WINDOW_LENGTH, len_data);
            write_register(REG_SHIFT_AMOUNT, shift_data);
            if ($urandom_range(0, 7) == 0)
                write_register(($urandom_range(0, 1) != 0) ? REG_SPARE_2 : REG_SPARE_3,
                               7'($urandom));
            eff_len = (len_data == '0) ? 1 :
                      ((int'(len_data) > DEPTH_DEF) ? DEPTH_DEF : int'(len_data));
            count   = eff_len + $urandom_range(4, 40);
            bias    = (phase < 2) ? BIAS_MIXED : t_sample_bias'($urandom_range(0, 2));
            set_idling(t_idle_mode'(phase % 4));
            repeat (count) send_sample(pick_sample(bias));
            sent += count;
            phase++;
        end
        set_idling(IDLE_NONE);
        drain_results();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_window_extremes();
        test_shift_modes();
        test_spare_indexes();
        test_backpressure();
        test_random();

        // Anything still predicted never came out
        if (pending_averages.size() != 0) begin
            mismatches += pending_averages.size();
            $display("%0d predicted averages never arrived", pending_averages.size());
        end

        $display("Run: %0d samples in, %0d averages checked, %0d register writes, %0d mismatches",
                 samples_sent, averages_checked, cfg_writes, mismatches);
        $display("Input held back for %0d cycles; %0d cycles in all",
                 input_stall_cycles, cycle_count);
        if (mismatches == 0) begin
            $display("PASS moving_average_filter_top");
        end else begin
            $display("FAIL moving_average_filter_top");
        end
        $finish;
    end

endmodule
